[design/rpn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [3:0] FUNC_PUSH = 4'd0;
    localparam logic [3:0] FUNC_ADD  = 4'd1;
    localparam logic [3:0] FUNC_SUB  = 4'd2;
    localparam logic [3:0] FUNC_MUL  = 4'd3;
    localparam logic [3:0] FUNC_DIV  = 4'd4;
    localparam logic [3:0] FUNC_MOD  = 4'd5;
    localparam logic [3:0] FUNC_PEEK = 4'd6;
    localparam logic [3:0] FUNC_DUP  = 4'd7;
    localparam logic [3:0] FUNC_SWAP = 4'd8;
    localparam logic [3:0] FUNC_CLR  = 4'd9;
    localparam logic [3:0] FUNC_POP  = 4'd10;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] operand;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic               value_valid;
        logic               underflow;
        logic               overflow;
        logic               zero_divisor;
        logic [7:0]         depth;
    } t_out_item;

    // datapath operations driven by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,    // latch command, issue read of top
        OP_POPB,    // take top as b, issue read of next
        OP_POPA,    // take read as a
        OP_DIVSTEP, // one divider step: load, then iterations
        OP_EXEC,    // compute result, push/write
        OP_SWAPW,   // second write of swap
        OP_DONE     // present result
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        logic [3:0] func;
        logic       div_done;
        logic       zdiv;
    } t_sts;

endpackage

[design/rpn_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_datapath
// Stack memory, pointer, operand registers, ALU and shared radix-2 divider.
// ----------------------------------------------------------------------------
module rpn_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpn_pkg::t_in_item i_item,
    input  rpn_pkg::t_ctl     i_ctl,
    output rpn_pkg::t_sts     o_sts,
    output rpn_pkg::t_out_item o_res
);
    localparam int SW = rpn_pkg::SP_W;
    localparam int AW = rpn_pkg::ADDR_W;

    logic [31:0] r_mem [rpn_pkg::STACK_DEPTH];
    logic [31:0] r_rd;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    logic [SW-1:0] r_sp, n_sp;
    logic [3:0]    r_func;
    logic signed [31:0] r_opnd, r_a, r_b, r_top;
    logic r_under, r_over, r_zdiv, r_valid, n_under, n_over, n_zdiv, n_valid;
    logic signed [31:0] r_value, n_value;

    // divider: |num| (64 bits) / |den| (32 bits), restoring, one bit a cycle
    // div: num = |a| << 16, den = |b|; mod: num = |a| >> 16, den = |b| >> 16
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_neg;
    logic [32:0] trial;
    logic [63:0] num_abs;
    logic [31:0] den_abs;
    logic [31:0] a_mag, b_mag;
    logic        pop_b;
    logic        rd_int_zero;

    assign trial = {r_rem[31:0], r_q[63]} - {1'b0, r_den};

    // commands that pop the top
    assign pop_b = (r_func == rpn_pkg::FUNC_ADD) || (r_func == rpn_pkg::FUNC_SUB) ||
                   (r_func == rpn_pkg::FUNC_MUL) || (r_func == rpn_pkg::FUNC_DIV) ||
                   (r_func == rpn_pkg::FUNC_MOD) || (r_func == rpn_pkg::FUNC_POP);

    // top truncates to integer 0: -65536 < top < 65536
    assign rd_int_zero = (r_rd[31:16] == 16'h0000) ||
                         (r_rd[31:16] == 16'hFFFF && r_rd[15:0] != 16'h0000);

    // mem read address follows the pointer
    always_comb begin
        rd_addr = '0;
        if (i_ctl.op == rpn_pkg::OP_LOAD) rd_addr = AW'(r_sp - SW'(1));
        else if (i_ctl.op == rpn_pkg::OP_POPB) rd_addr = AW'(r_sp - SW'(2));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == rpn_pkg::OP_LOAD || i_ctl.op == rpn_pkg::OP_POPB)
            r_rd <= r_mem[rd_addr];
        if (wr_en) r_mem[wr_addr] <= wr_data;
    end

    logic signed [32:0] sum33;
    logic signed [63:0] prod;
    logic signed [63:0] prod_r;
    logic signed [63:0] quo;
    logic signed [31:0] rem_i;
    logic signed [31:0] res;
    logic signed [47:0] prod_sh;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -64'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    assign prod   = r_a * r_b;
    assign prod_r = prod + 64'sd32768;
    assign prod_sh = prod_r[63:16];
    assign quo    = r_neg ? -$signed(r_q) : $signed(r_q);
    assign a_mag  = r_a[31] ? 32'(-r_a) : r_a;
    assign b_mag  = r_b[31] ? 32'(-r_b) : r_b;
    assign num_abs = (r_func == rpn_pkg::FUNC_MOD) ? {48'd0, a_mag[31:16]}
                                                   : {16'd0, a_mag, 16'd0};
    assign den_abs = (r_func == rpn_pkg::FUNC_MOD) ? {16'd0, b_mag[31:16]} : b_mag;

    always_comb begin
        sum33 = '0;
        res = '0;
        rem_i = '0;
        unique case (r_func)
            rpn_pkg::FUNC_ADD: begin
                sum33 = 33'(r_a) + 33'(r_b);
                res = sat64(64'(sum33));
            end
            rpn_pkg::FUNC_SUB: begin
                sum33 = 33'(r_a) - 33'(r_b);
                res = sat64(64'(sum33));
            end
            rpn_pkg::FUNC_MUL: res = sat64(64'(prod_sh));
            rpn_pkg::FUNC_DIV: res = sat64(quo);
            rpn_pkg::FUNC_MOD: begin
                // remainder magnitude stays below 2^15, so no saturation
                rem_i = r_neg ? -$signed(r_rem[31:0]) : $signed(r_rem[31:0]);
                res = {rem_i[15:0], 16'd0};
            end
            default: res = r_opnd;
        endcase
    end

    always_comb begin
        n_sp = r_sp; n_under = r_under; n_over = r_over; n_zdiv = r_zdiv;
        n_valid = r_valid; n_value = r_value;
        wr_en = 1'b0; wr_addr = '0; wr_data = r_opnd;
        unique case (i_ctl.op)
            rpn_pkg::OP_LOAD: begin
                n_under = 1'b0; n_over = 1'b0; n_zdiv = 1'b0;
                n_valid = 1'b0; n_value = '0;
            end
            rpn_pkg::OP_POPB: begin
                if (pop_b) begin
                    if (r_sp != '0) n_sp = r_sp - SW'(1);
                    else n_under = 1'b1;
                end
                if (r_func == rpn_pkg::FUNC_DIV)
                    n_zdiv = (r_sp == '0) || (r_rd == '0);
                else if (r_func == rpn_pkg::FUNC_MOD)
                    n_zdiv = (r_sp == '0) || rd_int_zero;
            end
            rpn_pkg::OP_POPA: begin
                // swap only reads the second entry
                if (r_func != rpn_pkg::FUNC_SWAP) begin
                    if (r_sp != '0) n_sp = r_sp - SW'(1);
                    else n_under = 1'b1;
                end
            end
            rpn_pkg::OP_EXEC: begin
                unique case (r_func)
                    rpn_pkg::FUNC_PUSH, rpn_pkg::FUNC_ADD, rpn_pkg::FUNC_SUB,
                    rpn_pkg::FUNC_MUL, rpn_pkg::FUNC_DIV, rpn_pkg::FUNC_MOD: begin
                        if ((r_func == rpn_pkg::FUNC_DIV || r_func == rpn_pkg::FUNC_MOD)
                            && r_zdiv) begin
                        end else if (r_sp < SW'(rpn_pkg::STACK_DEPTH)) begin
                            wr_en = 1'b1; wr_addr = AW'(r_sp);
                            wr_data = res; n_sp = r_sp + SW'(1);
                        end else n_over = 1'b1;
                    end
                    rpn_pkg::FUNC_PEEK: if (r_sp != '0) begin
                        n_valid = 1'b1; n_value = r_top;
                    end
                    rpn_pkg::FUNC_DUP:
                        if (r_sp != '0 && r_sp < SW'(rpn_pkg::STACK_DEPTH)) begin
                            wr_en = 1'b1; wr_addr = AW'(r_sp);
                            wr_data = r_top; n_sp = r_sp + SW'(1);
                        end
                    rpn_pkg::FUNC_SWAP: if (r_sp > SW'(1)) begin
                        wr_en = 1'b1; wr_addr = AW'(r_sp - SW'(1)); wr_data = r_a;
                    end
                    rpn_pkg::FUNC_CLR: n_sp = '0;
                    rpn_pkg::FUNC_POP: begin
                        n_valid = 1'b1; n_value = r_b;
                    end
                    default: ;
                endcase
            end
            rpn_pkg::OP_SWAPW:
                if (r_func == rpn_pkg::FUNC_SWAP && r_sp > SW'(1)) begin
                    wr_en = 1'b1; wr_addr = AW'(r_sp - SW'(2)); wr_data = r_top;
                end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else begin
            r_sp <= n_sp;
        end
        r_under <= n_under; r_over <= n_over; r_valid <= n_valid; r_value <= n_value;
        r_zdiv <= n_zdiv;
        unique case (i_ctl.op)
            rpn_pkg::OP_LOAD: begin
                r_func <= i_item.func; r_opnd <= i_item.operand;
                r_a <= '0; r_b <= '0;
            end
            rpn_pkg::OP_POPB: begin
                // r_rd holds top; for swap/peek/dup keep as r_top
                r_top <= r_rd;
                r_b <= (r_sp != '0) ? r_rd : '0;
            end
            rpn_pkg::OP_POPA: begin
                r_a <= (r_sp != '0) ? r_rd : '0;
                r_cnt <= '0;
            end
            rpn_pkg::OP_DIVSTEP: begin
                if (r_cnt == '0) begin
                    r_q <= num_abs; r_rem <= '0; r_den <= den_abs;
                    r_neg <= (r_func == rpn_pkg::FUNC_MOD) ? r_a[31] : (r_a[31] ^ r_b[31]);
                end else begin
                    if (!trial[32]) begin
                        r_rem <= trial; r_q <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[31:0], r_q[63]}; r_q <= {r_q[62:0], 1'b0};
                    end
                end
                r_cnt <= r_cnt + 7'd1;
            end
            default: ;
        endcase
    end

    // div_done after the load step and 64 iteration steps
    assign o_sts.func = r_func;
    assign o_sts.div_done = (r_cnt == 7'd65);
    assign o_sts.zdiv = r_zdiv;
    assign o_res.value = r_value;
    assign o_res.value_valid = r_valid;
    assign o_res.underflow = r_under;
    assign o_res.overflow = r_over;
    assign o_res.zero_divisor = r_zdiv &
        (r_func == rpn_pkg::FUNC_DIV || r_func == rpn_pkg::FUNC_MOD);
    assign o_res.depth = 8'(r_sp);
endmodule

[design/rpn_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_ctrl
// Command sequencer of the stack calculator.
// ----------------------------------------------------------------------------
module rpn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  rpn_pkg::t_sts i_sts,
    output rpn_pkg::t_ctl o_ctl,
    output logic          o_busy,
    output logic          o_done
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001, S_POPB = 8'b0000_0010, S_WAIT = 8'b0000_0100,
        S_POPA = 8'b0000_1000, S_DIV  = 8'b0001_0000, S_EXEC = 8'b0010_0000,
        S_SWAP = 8'b0100_0000, S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic two_ops;

    // commands that pop a second operand (div/mod only without zero divisor)
    assign two_ops = (i_sts.func == rpn_pkg::FUNC_ADD) || (i_sts.func == rpn_pkg::FUNC_SUB)
        || (i_sts.func == rpn_pkg::FUNC_MUL)
        || ((i_sts.func == rpn_pkg::FUNC_DIV || i_sts.func == rpn_pkg::FUNC_MOD)
            && !i_sts.zdiv);

    always_comb begin
        n_state = r_state;
        o_ctl.op = rpn_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                o_ctl.op = rpn_pkg::OP_LOAD; n_state = S_POPB;
            end
            S_POPB: begin
                // read data of the top is ready now; datapath pops by command
                o_ctl.op = rpn_pkg::OP_POPB;
                n_state = S_WAIT;
            end
            S_WAIT: n_state = S_POPA;
            S_POPA: begin
                // swap also takes the second entry here, without popping
                if (two_ops || i_sts.func == rpn_pkg::FUNC_SWAP) o_ctl.op = rpn_pkg::OP_POPA;
                if (two_ops && (i_sts.func == rpn_pkg::FUNC_DIV ||
                                i_sts.func == rpn_pkg::FUNC_MOD))
                    n_state = S_DIV;
                else n_state = S_EXEC;
            end
            S_DIV: begin
                o_ctl.op = rpn_pkg::OP_DIVSTEP;
                if (i_sts.div_done) begin
                    o_ctl.op = rpn_pkg::OP_NONE; n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.op = rpn_pkg::OP_EXEC; n_state = S_SWAP;
            end
            S_SWAP: begin
                o_ctl.op = rpn_pkg::OP_SWAPW; n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
endmodule

[design/rpn_stack_calculator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish calculator on a 128-entry Q16.16 value stack.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: drive i_item and raise i_start; the item is taken at an
//    edge where i_start is high and o_busy is low.
//  - Result channel: o_res is valid for exactly one cycle while o_done is
//    high. The receiver cannot stall; it must take the item then.
//  - Sequence: a command passes the POPB, WAIT, POPA, EXEC and SWAP states
//    before its result; div and mod with a nonzero divisor also run the
//    64-step restoring divider (shared by both) in DIV. o_busy drops with the
//    result, so the next command is accepted only after it: one command at
//    a time.
//  - Pops walk the top two entries through the single stack memory read
//    port, one registered read per cycle; swap writes back in EXEC and SWAP.
//  - Reset (i_rst_n low, synchronous) empties the stack and idles the
//    sequencer. Stack contents are not cleared; only entries below the
//    pointer are ever used.
// ----------------------------------------------------------------------------
module rpn_stack_calculator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  rpn_pkg::t_in_item  i_item,
    output logic               o_busy,
    output logic               o_done,
    output rpn_pkg::t_out_item o_res
);
    rpn_pkg::t_ctl ctl;
    rpn_pkg::t_sts sts;

    rpn_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_sts(sts),
        .o_ctl(ctl), .o_busy(o_busy), .o_done(o_done)
    );

    rpn_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_ctl(ctl),
        .o_sts(sts), .o_res(o_res)
    );

`ifndef NO_ASSERTIONS
    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    // depth never exceeds the stack size
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.depth <= 8'd128) else $error("depth overrun");
    // acceptance makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("not busy");
`endif
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stack calculator: a stack model predicts each
// result, a small scoreboard compares the strobed results in order.
// ----------------------------------------------------------------------------
module tb;

    // scoreboard of predicted results, oldest first
    class calc_scoreboard;
        rpn_pkg::t_out_item pending[$];
        int                 n_err;

        function void note_item(rpn_pkg::t_out_item exp_res);
            pending.push_back(exp_res);
        endfunction

        function void check_result(rpn_pkg::t_out_item got);
            rpn_pkg::t_out_item exp_res;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_res = pending.pop_front();
            if (got.value !== exp_res.value || got.value_valid !== exp_res.value_valid ||
                got.underflow !== exp_res.underflow ||
                got.overflow !== exp_res.overflow ||
                got.zero_divisor !== exp_res.zero_divisor ||
                got.depth !== exp_res.depth) begin
                n_err++;
                if (n_err <= 10)
                    $display({"mismatch: exp v=%h vv=%b u=%b o=%b z=%b d=%0d",
                              " got v=%h vv=%b u=%b o=%b z=%b d=%0d"},
                        exp_res.value, exp_res.value_valid, exp_res.underflow,
                        exp_res.overflow, exp_res.zero_divisor, exp_res.depth,
                        got.value, got.value_valid, got.underflow, got.overflow,
                        got.zero_divisor, got.depth);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    rpn_pkg::t_in_item  i_item;
    logic               o_busy;
    logic               o_done;
    rpn_pkg::t_out_item o_res;

    rpn_stack_calculator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_item (i_item),
        .o_busy (o_busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

    calc_scoreboard sb;
    logic signed [31:0] model_stack [rpn_pkg::STACK_DEPTH];
    int                 model_sp;
    bit                 pop_under;
    bit                 push_over;
    longint             cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] stack_pop();
        if (model_sp > 0) begin
            model_sp--;
            return model_stack[model_sp];
        end
        pop_under = 1;
        return 0;
    endfunction

    function automatic void stack_push(logic signed [31:0] v);
        if (model_sp < rpn_pkg::STACK_DEPTH) begin
            model_stack[model_sp] = v;
            model_sp++;
        end else
            push_over = 1;
    endfunction

    // stack model: advances state and returns the expected result
    function automatic rpn_pkg::t_out_item calc_predict(rpn_pkg::t_in_item it);
        rpn_pkg::t_out_item r;
        longint a, b, p;
        int ta, tb;
        logic signed [31:0] t;
        r = '0;
        pop_under = 0;
        push_over = 0;
        case (it.func)
            rpn_pkg::FUNC_PUSH: stack_push(it.operand);
            rpn_pkg::FUNC_ADD, rpn_pkg::FUNC_SUB, rpn_pkg::FUNC_MUL: begin
                b = stack_pop();
                a = stack_pop();
                if (it.func == rpn_pkg::FUNC_ADD) stack_push(sat32(a + b));
                else if (it.func == rpn_pkg::FUNC_SUB) stack_push(sat32(a - b));
                else begin
                    p = a * b + 32768;
                    stack_push(sat32(p >>> 16));
                end
            end
            rpn_pkg::FUNC_DIV: begin
                b = stack_pop();
                if (b == 0) r.zero_divisor = 1;
                else begin
                    a = stack_pop();
                    stack_push(sat32((a * 65536) / b));
                end
            end
            rpn_pkg::FUNC_MOD: begin
                b = stack_pop();
                tb = int'(b) / 65536;
                if (tb == 0) r.zero_divisor = 1;
                else begin
                    a = stack_pop();
                    ta = int'(a) / 65536;
                    stack_push(sat32(longint'(ta % tb) * 65536));
                end
            end
            rpn_pkg::FUNC_PEEK: if (model_sp > 0) begin
                r.value = model_stack[model_sp-1];
                r.value_valid = 1;
            end
            rpn_pkg::FUNC_DUP: if (model_sp > 0 && model_sp < rpn_pkg::STACK_DEPTH)
                stack_push(model_stack[model_sp-1]);
            rpn_pkg::FUNC_SWAP: if (model_sp > 1) begin
                t = model_stack[model_sp-1];
                model_stack[model_sp-1] = model_stack[model_sp-2];
                model_stack[model_sp-2] = t;
            end
            rpn_pkg::FUNC_CLR: model_sp = 0;
            rpn_pkg::FUNC_POP: begin
                r.value = stack_pop();
                r.value_valid = 1;
            end
            default: ;
        endcase
        r.underflow = pop_under;
        r.overflow = push_over;
        r.depth = model_sp[7:0];
        return r;
    endfunction

    // drive one command at the falling edge and hold it until accepted
    task automatic send_cmd(logic [3:0] f, logic [31:0] opnd);
        i_item.func = f;
        i_item.operand = opnd;
        i_start = 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_item(calc_predict(i_item));
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    // operands: half small fixed-point numbers, else corner values or full-range random
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            3: return 0;
            4: return $urandom_range(0, 65535);
            default: return {{12{1'b0}}, 4'($urandom()), 16'($urandom())} *
                            ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    function automatic logic [3:0] rand_func();
        int k;
        k = $urandom_range(0, 99);
        if (k < 30) return rpn_pkg::FUNC_PUSH;
        if (k < 97) return 4'($urandom_range(1, 10));
        return 4'($urandom_range(11, 15));
    endfunction

    // results are strobed for a single cycle; take them at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_res);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > 1000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int burst;
        int wait_cnt;
        sb = new();
        cycle_cnt = 0;
        model_sp = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty-stack cases, arithmetic corners, full stack
        send_cmd(rpn_pkg::FUNC_POP, 0);
        send_cmd(rpn_pkg::FUNC_PEEK, 0);
        send_cmd(rpn_pkg::FUNC_ADD, 0);
        send_cmd(rpn_pkg::FUNC_DUP, 0);
        send_cmd(rpn_pkg::FUNC_SWAP, 0);
        send_cmd(4'd13, 0);
        send_cmd(rpn_pkg::FUNC_PUSH, 32'h7fffffff);
        send_cmd(rpn_pkg::FUNC_DUP, 0);
        send_cmd(rpn_pkg::FUNC_ADD, 0);
        send_cmd(rpn_pkg::FUNC_PUSH, 32'h80000000);
        send_cmd(rpn_pkg::FUNC_SWAP, 0);
        send_cmd(rpn_pkg::FUNC_SUB, 0);
        send_cmd(rpn_pkg::FUNC_PUSH, 32'h80000000);
        send_cmd(rpn_pkg::FUNC_DUP, 0);
        send_cmd(rpn_pkg::FUNC_MUL, 0);
        send_cmd(rpn_pkg::FUNC_PUSH, 32'h00030000);
        send_cmd(rpn_pkg::FUNC_PUSH, 0);
        send_cmd(rpn_pkg::FUNC_DIV, 0);
        send_cmd(rpn_pkg::FUNC_PUSH, 32'h00008000);
        send_cmd(rpn_pkg::FUNC_MOD, 0);
        send_cmd(rpn_pkg::FUNC_PUSH, 32'hfffe0000);
        send_cmd(rpn_pkg::FUNC_MOD, 0);
        send_cmd(rpn_pkg::FUNC_PUSH, 32'h00010000);
        send_cmd(rpn_pkg::FUNC_DIV, 0);
        send_cmd(rpn_pkg::FUNC_CLR, 0);
        for (int i = 0; i <= rpn_pkg::STACK_DEPTH; i++)
            send_cmd(rpn_pkg::FUNC_PUSH, $urandom());
        send_cmd(rpn_pkg::FUNC_DUP, 0);
        send_cmd(rpn_pkg::FUNC_SWAP, 0);
        send_cmd(rpn_pkg::FUNC_PEEK, 0);
        send_cmd(rpn_pkg::FUNC_CLR, 0);

        // random bursts with random gaps
        for (int n = 0; n < 950; ) begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst; j++, n++) send_cmd(rand_func(), rand_operand());
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 90)) @(negedge i_clk);
        end

        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < 1000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (80) @(posedge i_clk);
        if (sb.n_err == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
